FILE: design/atlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atlr_pkg
// Shared constants, types and arithmetic helpers of the antialiased line raster.
// ----------------------------------------------------------------------------
package atlr_pkg;

	localparam int X_EXTENT    = 240;
	localparam int Y_EXTENT    = 135;
	localparam int STORE_DEPTH = X_EXTENT * Y_EXTENT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int COORD_W     = 12;
	localparam int FIELD_W     = 10;
	localparam int COLOUR_W    = 24;
	localparam int RADIUS_W    = 4;
	localparam int Q_W         = 32;
	localparam int DIV_STEPS   = 27;
	localparam int DIV_CNT_W   = 5;
	localparam int PROD_W      = ADDR_W + COORD_W;
	localparam int CFG_IDX_W   = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [FIELD_W-1:0] field_t;

	typedef enum logic [1:0] {
		ACT_LINE  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE = 3'd0,
		CFG_LEFT   = 3'd1,
		CFG_RIGHT  = 3'd2,
		CFG_TOP    = 3'd3,
		CFG_BOTTOM = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		action_t             act;
		logic                on;
		logic [ADDR_W-1:0]   addr;
		field_t              sx;
		field_t              sy;
		field_t              ex;
		field_t              ey;
		logic [COLOUR_W-1:0] colour;
		logic [RADIUS_W-1:0] radius;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

	typedef struct packed {
		logic   enable;
		field_t left;
		field_t right;
		field_t top;
		field_t bottom;
	} clip_t;

	function automatic logic [ADDR_W-1:0] pix_addr(input coord_t i, input coord_t j);
		logic [PROD_W-1:0] p;
		p = PROD_W'($unsigned(j)) * PROD_W'(X_EXTENT) + PROD_W'($unsigned(i));
		return p[ADDR_W-1:0];
	endfunction

	function automatic logic [7:0] mix8(input logic [7:0] o, input logic [7:0] n,
		input logic [8:0] a);
		logic [16:0] s;
		s = 17'(o) * 17'(9'd256 - a) + 17'(n) * 17'(a);
		return s[15:8];
	endfunction

endpackage
`default_nettype wire

FILE: design/atlr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atlr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module atlr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: design/atlr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atlr_front
// Accepts commands, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module atlr_front import atlr_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [1:0]          action,
	input  wire field_t              start_x,
	input  wire field_t              start_y,
	input  wire field_t              end_x,
	input  wire field_t              end_y,
	input  wire logic [7:0]          red,
	input  wire logic [7:0]          green,
	input  wire logic [7:0]          blue,
	input  wire logic [RADIUS_W-1:0] pen_radius,
	output cmd_chan_t                cmd_out,
	input  wire logic                cmd_pop
);

	cmd_t       entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	cmd_t       cmd_new;
	coord_t     sxc;
	coord_t     syc;
	logic       accept;
	logic       take;

	always_comb begin
		sxc = coord_t'(start_x);
		syc = coord_t'(start_y);
		cmd_new.act    = action_t'(action);
		cmd_new.on     = (sxc >= coord_t'(0)) && (sxc < coord_t'(X_EXTENT)) &&
			(syc >= coord_t'(0)) && (syc < coord_t'(Y_EXTENT));
		cmd_new.addr   = cmd_new.on ? pix_addr(sxc, syc) : '0;
		cmd_new.sx     = start_x;
		cmd_new.sy     = start_y;
		cmd_new.ex     = end_x;
		cmd_new.ey     = end_y;
		cmd_new.colour = {red, green, blue};
		cmd_new.radius = pen_radius;
	end

	assign full          = (cnt_q == 2'd2);
	assign accept        = push && !full;
	assign take          = cmd_pop && (cnt_q != 2'd0);
	assign cmd_out.valid = (cnt_q != 2'd0);
	assign cmd_out.cmd   = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q[wr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (accept) begin
				wr_q <= ~wr_q;
			end
			if (take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(accept) - 2'(take);
		end
	end

endmodule
`default_nettype wire

FILE: design/atlr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atlr_back
// Executes commands: line setup, gradient divide, disk blending over the frame
// store by read-modify-write, and single pixel writes and reads.
// ----------------------------------------------------------------------------
module atlr_back import atlr_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cmd_chan_t           cmd_in,
	output logic                     cmd_pop,
	input  wire clip_t               clip,
	output logic                     res_valid,
	output logic [COLOUR_W-1:0]      res_data,
	input  wire logic                res_ready
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_SETUP  = 10'b0000000010,
		S_DIV    = 10'b0000000100,
		S_PLOT   = 10'b0000001000,
		S_CELL   = 10'b0000010000,
		S_RMW    = 10'b0000100000,
		S_PWRITE = 10'b0001000000,
		S_PREAD  = 10'b0010000000,
		S_PWAIT  = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	typedef enum logic [3:0] {
		PH_ENDA    = 4'b0001,
		PH_ENDB    = 4'b0010,
		PH_SPAN_LO = 4'b0100,
		PH_SPAN_HI = 4'b1000
	} phase_t;

	state_t                state_q, state_n;
	phase_t                ph_q, ph_n;
	cmd_t                  cmd_q, cmd_n;
	logic                  steep_q, steep_n;
	coord_t                x0_q, y0_q, x1_q, y1_q, x0_n, y0_n, x1_n, y1_n;
	logic [10:0]           dx_q, dx_n;
	logic                  dneg_q, dneg_n;
	logic [11:0]           rem_q, rem_n;
	logic [DIV_STEPS-1:0]  quo_q, quo_n;
	logic [DIV_CNT_W-1:0]  dcnt_q, dcnt_n;
	logic signed [Q_W-1:0] g_q, g_n, intery_q, intery_n;
	coord_t                xm_q, xm_n;
	coord_t                cx_q, cy_q, cx_n, cy_n;
	logic [8:0]            alpha_q, alpha_n;
	coord_t                i_q, j_q, j0_q, i1_q, j1_q;
	coord_t                i_n, j_n, j0_n, i1_n, j1_n;
	logic [ADDR_W-1:0]     addr_q, addr_n;
	logic [COLOUR_W-1:0]   res_q, res_n;

	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
	logic [COLOUR_W-1:0]   ram_wdata, ram_rdata;

	coord_t                sx, sy, ex, ey, ax, ay, a0, b0, a1, b1, dyv;
	logic                  stp;
	logic [11:0]           rem_sh;
	logic                  ge;
	logic [DIV_STEPS-1:0]  quo_step;
	logic signed [Q_W-1:0] mag, g_fin, y0w;
	coord_t                fl, maj, mnr, pcx, pcy, rr, ilo, ihi, jlo, jhi;
	logic [7:0]            fr;
	logic [8:0]            palpha;
	logic                  go_disk;
	coord_t                di, dj, adi, adj;
	logic [8:0]            d2, r2;
	logic                  in_disk;

	atlr_ram #(.WIDTH(COLOUR_W), .DEPTH(STORE_DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign res_valid = (state_q == S_DONE);
	assign res_data  = res_q;

	always_comb begin
		sx  = coord_t'(cmd_q.sx);
		sy  = coord_t'(cmd_q.sy);
		ex  = coord_t'(cmd_q.ex);
		ey  = coord_t'(cmd_q.ey);
		ax  = (ex > sx) ? ex - sx : sx - ex;
		ay  = (ey > sy) ? ey - sy : sy - ey;
		stp = ay > ax;
		a0  = stp ? sy : sx;
		b0  = stp ? sx : sy;
		a1  = stp ? ey : ex;
		b1  = stp ? ex : ey;
		if (a0 > a1) begin
			{a0, a1} = {a1, a0};
			{b0, b1} = {b1, b0};
		end
		dyv = b1 - b0;

		rem_sh   = {rem_q[10:0], quo_q[DIV_STEPS-1]};
		ge       = rem_sh >= {1'b0, dx_q};
		quo_step = {quo_q[DIV_STEPS-2:0], ge};
		mag      = Q_W'(quo_step[16:0]);
		g_fin    = dneg_q ? -mag : mag;
		y0w      = Q_W'(y0_q);

		fl = coord_t'(intery_q >>> 16);
		fr = intery_q[15:8];
		rr = coord_t'(cmd_q.radius);
		maj = x0_q;
		mnr = y0_q;
		palpha = 9'd256;
		go_disk = 1'b0;
		case (ph_q)
			PH_ENDA: begin
				maj = x0_q; mnr = y0_q; go_disk = 1'b1;
			end
			PH_ENDB: begin
				maj = x1_q; mnr = y1_q; go_disk = 1'b1;
			end
			PH_SPAN_LO: begin
				maj = xm_q; mnr = fl; palpha = 9'd256 - {1'b0, fr};
				go_disk = (xm_q < x1_q);
			end
			PH_SPAN_HI: begin
				maj = xm_q; mnr = fl + coord_t'(1); palpha = {1'b0, fr};
				go_disk = (fr != 8'd0);
			end
			default: begin
				go_disk = 1'b0;
			end
		endcase
		pcx = steep_q ? mnr : maj;
		pcy = steep_q ? maj : mnr;
		ilo = pcx - rr;
		ihi = pcx + rr;
		jlo = pcy - rr;
		jhi = pcy + rr;
		if (ilo < coord_t'(0)) ilo = coord_t'(0);
		if (ihi > coord_t'(X_EXTENT - 1)) ihi = coord_t'(X_EXTENT - 1);
		if (jlo < coord_t'(0)) jlo = coord_t'(0);
		if (jhi > coord_t'(Y_EXTENT - 1)) jhi = coord_t'(Y_EXTENT - 1);
		if (clip.enable) begin
			if (ilo < coord_t'(clip.left)) ilo = coord_t'(clip.left);
			if (ihi > coord_t'(clip.right)) ihi = coord_t'(clip.right);
			if (jlo < coord_t'(clip.top)) jlo = coord_t'(clip.top);
			if (jhi > coord_t'(clip.bottom)) jhi = coord_t'(clip.bottom);
		end

		di  = i_q - cx_q;
		dj  = j_q - cy_q;
		adi = di[COORD_W-1] ? -di : di;
		adj = dj[COORD_W-1] ? -dj : dj;
		d2  = 9'(adi[3:0]) * 9'(adi[3:0]) + 9'(adj[3:0]) * 9'(adj[3:0]);
		r2  = 9'(cmd_q.radius) * 9'(cmd_q.radius);
		in_disk = d2 <= r2;
	end

	always_comb begin
		state_n  = state_q;
		ph_n     = ph_q;
		cmd_n    = cmd_q;
		steep_n  = steep_q;
		x0_n     = x0_q; y0_n = y0_q; x1_n = x1_q; y1_n = y1_q;
		dx_n     = dx_q;
		dneg_n   = dneg_q;
		rem_n    = rem_q;
		quo_n    = quo_q;
		dcnt_n   = dcnt_q;
		g_n      = g_q;
		intery_n = intery_q;
		xm_n     = xm_q;
		cx_n     = cx_q; cy_n = cy_q;
		alpha_n  = alpha_q;
		i_n      = i_q; j_n = j_q; j0_n = j0_q; i1_n = i1_q; j1_n = j1_q;
		addr_n   = addr_q;
		res_n    = res_q;
		cmd_pop  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = {mix8(ram_rdata[23:16], cmd_q.colour[23:16], alpha_q),
			mix8(ram_rdata[15:8], cmd_q.colour[15:8], alpha_q),
			mix8(ram_rdata[7:0], cmd_q.colour[7:0], alpha_q)};
		ram_raddr = (state_q == S_CELL) ? pix_addr(i_q, j_q) : cmd_q.addr;

		case (state_q)
			S_IDLE: begin
				if (cmd_in.valid) begin
					cmd_pop = 1'b1;
					cmd_n   = cmd_in.cmd;
					res_n   = '0;
					case (cmd_in.cmd.act)
						ACT_LINE:  state_n = S_SETUP;
						ACT_WRITE: state_n = S_PWRITE;
						ACT_READ:  state_n = S_PREAD;
						default:   state_n = S_DONE;
					endcase
				end
			end
			S_SETUP: begin
				steep_n = stp;
				x0_n    = a0; y0_n = b0; x1_n = a1; y1_n = b1;
				dx_n    = 11'(a1 - a0);
				dneg_n  = dyv[COORD_W-1];
				rem_n   = '0;
				quo_n   = {(dyv[COORD_W-1] ? 11'(-dyv) : 11'(dyv)), 16'd0};
				dcnt_n  = '0;
				ph_n    = PH_ENDA;
				if (a1 == a0) begin
					g_n      = Q_W'(32'sd65536);
					intery_n = (Q_W'(b0) <<< 16) + Q_W'(32'sd65536);
					state_n  = S_PLOT;
				end else begin
					state_n = S_DIV;
				end
			end
			S_DIV: begin
				rem_n  = ge ? rem_sh - {1'b0, dx_q} : rem_sh;
				quo_n  = quo_step;
				dcnt_n = dcnt_q + DIV_CNT_W'(1);
				if (dcnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					g_n      = g_fin;
					intery_n = (y0w <<< 16) + g_fin;
					state_n  = S_PLOT;
				end
			end
			S_PLOT: begin
				case (ph_q)
					PH_ENDA: ph_n = PH_ENDB;
					PH_ENDB: begin
						ph_n = PH_SPAN_LO;
						xm_n = x0_q + coord_t'(1);
					end
					PH_SPAN_LO: ph_n = PH_SPAN_HI;
					default: begin
						ph_n     = PH_SPAN_LO;
						xm_n     = xm_q + coord_t'(1);
						intery_n = intery_q + g_q;
					end
				endcase
				if ((ph_q == PH_SPAN_LO) && !go_disk) begin
					state_n = S_DONE;
				end else if (go_disk && (ilo <= ihi) && (jlo <= jhi)) begin
					cx_n    = pcx;
					cy_n    = pcy;
					alpha_n = palpha;
					i_n     = ilo;
					j_n     = jlo;
					j0_n    = jlo;
					i1_n    = ihi;
					j1_n    = jhi;
					state_n = S_CELL;
				end
			end
			S_CELL, S_RMW: begin
				if ((state_q == S_CELL) && in_disk) begin
					addr_n  = ram_raddr;
					state_n = S_RMW;
				end else begin
					if (state_q == S_RMW) begin
						ram_we = 1'b1;
					end
					state_n = S_CELL;
					if (j_q == j1_q) begin
						j_n = j0_q;
						if (i_q == i1_q) begin
							state_n = S_PLOT;
						end else begin
							i_n = i_q + coord_t'(1);
						end
					end else begin
						j_n = j_q + coord_t'(1);
					end
				end
			end
			S_PWRITE: begin
				ram_we    = cmd_q.on;
				ram_waddr = cmd_q.addr;
				ram_wdata = cmd_q.colour;
				state_n   = S_DONE;
			end
			S_PREAD: begin
				state_n = S_PWAIT;
			end
			S_PWAIT: begin
				res_n   = cmd_q.on ? ram_rdata : '0;
				state_n = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= PH_ENDA;
		end else begin
			state_q <= state_n;
			ph_q    <= ph_n;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_n;
		steep_q  <= steep_n;
		x0_q     <= x0_n;
		y0_q     <= y0_n;
		x1_q     <= x1_n;
		y1_q     <= y1_n;
		dx_q     <= dx_n;
		dneg_q   <= dneg_n;
		rem_q    <= rem_n;
		quo_q    <= quo_n;
		dcnt_q   <= dcnt_n;
		g_q      <= g_n;
		intery_q <= intery_n;
		xm_q     <= xm_n;
		cx_q     <= cx_n;
		cy_q     <= cy_n;
		alpha_q  <= alpha_n;
		i_q      <= i_n;
		j_q      <= j_n;
		j0_q     <= j0_n;
		i1_q     <= i1_n;
		j1_q     <= j1_n;
		addr_q   <= addr_n;
		res_q    <= res_n;
	end

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_RMW) || (state_q == S_PWRITE))
		else $error("Frame store written outside a write state.");

	a_rmw_after_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RMW) |-> $past(state_q == S_CELL))
		else $error("Blend write without a preceding read.");

	a_wait_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PWAIT) |-> $past(state_q == S_PREAD))
		else $error("Pixel read result taken without a read.");

	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_waddr < ADDR_W'(STORE_DEPTH)))
		else $error("Frame store write address beyond the store.");

endmodule
`default_nettype wire

FILE: design/antialiased_thick_line_raster.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// antialiased_thick_line_raster
// Antialiased thick line rasterizer over a 240x135 RGB frame store.
//
// Channel   Direction  Handshake            Payload
// command   in         push / full          action, coordinates, colour, pen_radius
// result    out        pop / empty          pixel_red, pixel_green, pixel_blue
// config    in         cfg_write            cfg_index, cfg_data
//
// In the executor, write pixel passes idle, write and done; read pixel idle, read,
// wait and done; an unused action idle and done. Draw line passes idle, setup and
// divider, unless both ends share one major position, then per disk a plot step, a
// cell step per box pixel and a blend per covered pixel (frame store port bound).
// Two commands queue ahead of the executor and two items wait on the result side.
// Reset empties the queues and disables the clip; the frame store is not cleared.
// ----------------------------------------------------------------------------
module antialiased_thick_line_raster import atlr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [1:0]           action,
	input  wire field_t               start_x,
	input  wire field_t               start_y,
	input  wire field_t               end_x,
	input  wire field_t               end_y,
	input  wire logic [7:0]           red,
	input  wire logic [7:0]           green,
	input  wire logic [7:0]           blue,
	input  wire logic [RADIUS_W-1:0]  pen_radius,
	output logic                      empty,
	input  wire logic                 pop,
	output logic [7:0]                pixel_red,
	output logic [7:0]                pixel_green,
	output logic [7:0]                pixel_blue,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [FIELD_W-1:0]   cfg_data
);

	clip_t               clip_q;
	cmd_chan_t           cmd_chan;
	logic                cmd_pop;
	logic                res_valid;
	logic [COLOUR_W-1:0] res_data;
	logic                res_ready;
	logic [COLOUR_W-1:0] rq_q [2];
	logic                rq_wr_q;
	logic                rq_rd_q;
	logic [1:0]          rq_cnt_q;
	logic                rq_push;
	logic                rq_pop;

	atlr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.action     (action),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.pen_radius (pen_radius),
		.cmd_out    (cmd_chan),
		.cmd_pop    (cmd_pop)
	);

	atlr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_in    (cmd_chan),
		.cmd_pop   (cmd_pop),
		.clip      (clip_q),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_ready (res_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q.enable <= 1'b0;
			clip_q.left   <= field_t'(0);
			clip_q.right  <= field_t'(X_EXTENT - 1);
			clip_q.top    <= field_t'(0);
			clip_q.bottom <= field_t'(Y_EXTENT - 1);
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ENABLE: clip_q.enable <= cfg_data[0];
				CFG_LEFT:   clip_q.left   <= field_t'(cfg_data);
				CFG_RIGHT:  clip_q.right  <= field_t'(cfg_data);
				CFG_TOP:    clip_q.top    <= field_t'(cfg_data);
				CFG_BOTTOM: clip_q.bottom <= field_t'(cfg_data);
				default: ;
			endcase
		end
	end

	assign res_ready = (rq_cnt_q != 2'd2);
	assign rq_push   = res_valid && res_ready;
	assign empty     = (rq_cnt_q == 2'd0);
	assign rq_pop    = pop && !empty;
	assign pixel_red   = rq_q[rq_rd_q][23:16];
	assign pixel_green = rq_q[rq_rd_q][15:8];
	assign pixel_blue  = rq_q[rq_rd_q][7:0];

	always_ff @(posedge clk) begin
		if (rq_push) begin
			rq_q[rq_wr_q] <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= 1'b0;
			rq_rd_q  <= 1'b0;
			rq_cnt_q <= 2'd0;
		end else begin
			if (rq_push) begin
				rq_wr_q <= ~rq_wr_q;
			end
			if (rq_pop) begin
				rq_rd_q <= ~rq_rd_q;
			end
			rq_cnt_q <= rq_cnt_q + 2'(rq_push) - 2'(rq_pop);
		end
	end

endmodule
`default_nettype wire
